### rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types, codes and helpers of the SDRAM refresh scheduler.
// ----------------------------------------------------------------------------
package srs_pkg;

   // scheduler states
   typedef enum logic [2:0] {
      SCHED_WAIT        = 3'd0,
      SCHED_PREP        = 3'd1,
      SCHED_PRECHARGE   = 3'd2,
      SCHED_PRECHARGING = 3'd3,
      SCHED_REFRESH     = 3'd4,
      SCHED_REFRESHING  = 3'd5,
      SCHED_IDLE        = 3'd6
   } sched_state_type;

   // command codes
   localparam logic [1:0] CMD_NOP       = 2'd0;
   localparam logic [1:0] CMD_PRECHARGE = 2'd1;
   localparam logic [1:0] CMD_REFRESH   = 2'd2;

   // register indexes on the control port
   localparam logic [1:0] REG_RAS      = 2'd0;
   localparam logic [1:0] REG_RP       = 2'd1;
   localparam logic [1:0] REG_RC       = 2'd2;
   localparam logic [1:0] REG_INTERVAL = 2'd3;

   localparam int TIMING_W   = 8;
   localparam int INTERVAL_W = 16;

   localparam logic [TIMING_W-1:0]   RAS_RESET      = 8'd8;
   localparam logic [TIMING_W-1:0]   RP_RESET       = 8'd3;
   localparam logic [TIMING_W-1:0]   RC_RESET       = 8'd12;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1560;

   typedef struct packed {
      logic [TIMING_W-1:0]   ras_cycles;
      logic [TIMING_W-1:0]   rp_cycles;
      logic [TIMING_W-1:0]   rc_cycles;
      logic [INTERVAL_W-1:0] refresh_interval;
   } cfg_type;

   typedef struct packed {
      logic cmd_ready;
      logic any_bank_active;
      logic may_refresh;
   } req_type;

   typedef struct packed {
      logic       close_all_rows;
      logic [1:0] cmd_code;
      logic       cmd_valid;
   } rsp_type;

   function automatic logic [TIMING_W-1:0] timing_last(input logic [TIMING_W-1:0] v);
      timing_last = (v == '0) ? '0 : v - 1'b1;
   endfunction

endpackage

### rtl/core/srs_sched.sv
// ----------------------------------------------------------------------------
// srs_sched
// Refresh state machine, delay counter and refresh interval timer.
// ----------------------------------------------------------------------------
module srs_sched (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  srs_pkg::req_type req,
   input  srs_pkg::cfg_type cfg,
   output srs_pkg::rsp_type rsp
);
   import srs_pkg::*;

   sched_state_type         state_ff, state_in;
   logic [TIMING_W-1:0]     delay_ff, delay_in;
   logic [INTERVAL_W-1:0]   interval_ff, interval_in;

   logic [TIMING_W-1:0]     max_delay;
   logic [TIMING_W-1:0]     delay_last;
   logic [INTERVAL_W-1:0]   timer_last;
   logic [INTERVAL_W+2:0]   times_seven;
   logic [INTERVAL_W-1:0]   seven_eighths;
   logic                    timer_is_last;
   logic                    delay_is_last;
   logic                    can_ref;
   logic                    must_ref;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SCHED_WAIT;
         delay_ff    <= '0;
         interval_ff <= '0;
      end else if (step) begin
         state_ff    <= state_in;
         delay_ff    <= delay_in;
         interval_ff <= interval_in;
      end
   end

   always_comb begin
      max_delay = cfg.ras_cycles;
      if (cfg.rp_cycles > max_delay) max_delay = cfg.rp_cycles;
      if (cfg.rc_cycles > max_delay) max_delay = cfg.rc_cycles;
      delay_last    = timing_last(max_delay);
      timer_last    = (cfg.refresh_interval == '0) ? '0 : cfg.refresh_interval - 1'b1;
      times_seven   = {cfg.refresh_interval, 3'b000} - {3'b000, cfg.refresh_interval};
      seven_eighths = times_seven[INTERVAL_W+2:3];
      timer_is_last = interval_ff >= timer_last;
      delay_is_last = delay_ff >= delay_last;
      can_ref       = interval_ff >= {2'b00, cfg.refresh_interval[INTERVAL_W-1:2]};
      must_ref      = interval_ff >= seven_eighths;
   end

   always_comb begin
      state_in    = state_ff;
      delay_in    = delay_is_last ? delay_ff : delay_ff + 1'b1;
      interval_in = timer_is_last ? '0 : interval_ff + 1'b1;
      rsp.cmd_valid      = 1'b0;
      rsp.cmd_code       = CMD_NOP;
      rsp.close_all_rows = 1'b0;
      case (state_ff)
         SCHED_PREP: begin
            rsp.cmd_valid = 1'b1;
            if (delay_ff >= timing_last(cfg.ras_cycles)) state_in = SCHED_PRECHARGE;
         end
         SCHED_PRECHARGE: begin
            rsp.cmd_valid      = 1'b1;
            rsp.cmd_code       = CMD_PRECHARGE;
            rsp.close_all_rows = 1'b1;
            delay_in           = '0;
            if (req.cmd_ready) state_in = SCHED_PRECHARGING;
         end
         SCHED_PRECHARGING: begin
            rsp.cmd_valid = 1'b1;
            if (delay_ff >= timing_last(cfg.rp_cycles)) state_in = SCHED_REFRESH;
         end
         SCHED_REFRESH: begin
            rsp.cmd_valid = 1'b1;
            rsp.cmd_code  = CMD_REFRESH;
            delay_in      = '0;
            if (req.cmd_ready) state_in = SCHED_REFRESHING;
         end
         SCHED_REFRESHING: begin
            rsp.cmd_valid = 1'b1;
            if (delay_is_last) begin
               if (req.may_refresh && can_ref) begin
                  // refresh again and restart the interval
                  state_in    = SCHED_REFRESH;
                  interval_in = '0;
               end else begin
                  state_in = SCHED_IDLE;
               end
            end
         end
         SCHED_IDLE: begin
            if (timer_is_last) state_in = SCHED_WAIT;
         end
         default: begin
            // wait, and the unused code behaves as wait
            delay_in = '0;
            if (must_ref) begin
               state_in = SCHED_PREP;
            end else if (can_ref && req.may_refresh) begin
               state_in = req.any_bank_active ? SCHED_PREP : SCHED_REFRESH;
            end
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      step && state_ff == SCHED_PRECHARGE && req.cmd_ready
      |=> state_ff == SCHED_PRECHARGING && delay_ff == '0)
      else $error("precharge accepted but scheduler did not enter precharging");

   assert property (@(posedge clock) disable iff (reset)
      step && state_ff == SCHED_REFRESH && req.cmd_ready
      |=> state_ff == SCHED_REFRESHING && delay_ff == '0)
      else $error("refresh accepted but scheduler did not enter refreshing");

   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff) && $stable(delay_ff) && $stable(interval_ff))
      else $error("scheduler state moved without a transaction");

endmodule

### rtl/core/sdram_refresh_scheduler.sv
// ----------------------------------------------------------------------------
// sdram_refresh_scheduler
// SDRAM auto-refresh scheduler: one clock tick of the memory controller in,
// one refresh command slot out, with timing registers on a control port.
// ----------------------------------------------------------------------------
//  channel   direction   handshake          payload
//  req_*     in          tvalid / tready    tick status (tdata, 8 bits)
//  rsp_*     out         tvalid / tready    command slot (tdata, 8 bits)
//  csr_*     in/out      psel / penable     timing registers, 32-bit data
//
//  One transaction per cycle while req_tready is high; its result is registered.
//  The scheduler state advances at acceptance through one combinational pass.
//  A two-entry output buffer keeps req_tready high while one result waits.
//  Reset is synchronous: state wait, counters zero, registers at defaults.
// ----------------------------------------------------------------------------
module sdram_refresh_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] may_refresh, [1] any_bank_active, [2] cmd_ready
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] cmd_valid, [2:1] cmd_code, [3] close_all_rows
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import srs_pkg::*;

   cfg_type    cfg_ff;
   req_type    req;
   rsp_type    rsp_next;
   rsp_type    out_ff;
   rsp_type    skid_ff;
   logic       out_valid_ff;
   logic       skid_valid_ff;
   logic       accept;
   logic       out_free;
   logic       csr_write;
   logic [1:0] reg_index;

   // control port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ras_cycles       <= RAS_RESET;
         cfg_ff.rp_cycles        <= RP_RESET;
         cfg_ff.rc_cycles        <= RC_RESET;
         cfg_ff.refresh_interval <= INTERVAL_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_RAS:      cfg_ff.ras_cycles       <= csr_pwdata[TIMING_W-1:0];
            REG_RP:       cfg_ff.rp_cycles        <= csr_pwdata[TIMING_W-1:0];
            REG_RC:       cfg_ff.rc_cycles        <= csr_pwdata[TIMING_W-1:0];
            REG_INTERVAL: cfg_ff.refresh_interval <= csr_pwdata[INTERVAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_RAS:      csr_prdata = {24'd0, cfg_ff.ras_cycles};
         REG_RP:       csr_prdata = {24'd0, cfg_ff.rp_cycles};
         REG_RC:       csr_prdata = {24'd0, cfg_ff.rc_cycles};
         REG_INTERVAL: csr_prdata = {16'd0, cfg_ff.refresh_interval};
         default:      csr_prdata = '0;
      endcase
   end

   // input transaction
   assign req_tready          = !skid_valid_ff;
   assign accept              = req_tvalid && req_tready;
   assign req.may_refresh     = req_tdata[0];
   assign req.any_bank_active = req_tdata[1];
   assign req.cmd_ready       = req_tdata[2];

   srs_sched u_sched (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .req   (req),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   // output register with skid entry
   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_next;
      end
      if (!out_free && accept) begin
         skid_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.close_all_rows, out_ff.cmd_code, out_ff.cmd_valid};

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a result while the output register is empty");

   assert property (@(posedge clock) disable iff (reset)
      accept && !out_free |=> skid_valid_ff && !req_tready)
      else $error("stalled transaction not parked in the skid entry");

   assert property (@(posedge clock) disable iff (reset)
      accept && out_free && !skid_valid_ff |=> out_valid_ff)
      else $error("accepted transaction did not reach the output register");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.close_all_rows |-> out_ff.cmd_code == CMD_PRECHARGE)
      else $error("row close flagged without a precharge command");

endmodule
